// ===== hw/rtl/cfv_pkg.sv =====
// Command frame validator package: frame constants, command and status codes, result type.
// Used by cfv_frame_check and command_frame_validator_top.
`default_nettype none

package cfv_pkg;

  localparam int unsigned IdxW = 10;

  localparam logic [7:0]  Preamble0    = 8'h0F;
  localparam logic [7:0]  Preamble1    = 8'hF0;
  localparam logic [7:0]  ColonChar    = 8'h3A;
  localparam logic [7:0]  AlarmOn      = 8'h70;
  localparam logic [7:0]  AlarmOff     = 8'h07;
  localparam logic [15:0] IdNone       = 16'h0000;
  localparam logic [15:0] IdAll        = 16'hFFFF;
  localparam logic [15:0] VersionReset = 16'd256;

  localparam logic [7:0] CmdQuery  = 8'h01;
  localparam logic [7:0] CmdTarget = 8'h02;
  localparam logic [7:0] CmdWifi   = 8'h03;
  localparam logic [7:0] CmdHost   = 8'h04;

  localparam logic [2:0] StReject = 3'd0;
  localparam logic [2:0] StQuery  = 3'd1;
  localparam logic [2:0] StTarget = 3'd2;
  localparam logic [2:0] StWifi   = 3'd3;
  localparam logic [2:0] StHost   = 3'd4;

  typedef struct packed {
    logic [7:0]  payload_len;
    logic [7:0]  split_pos;
    logic [15:0] value;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/command_frame_validator_top.sv =====
// Command frame validator top level: input register, frame checker, result register.
// Depends on cfv_pkg and cfv_frame_check.
//
// Use: frame bytes enter on the s_axis channel, one byte per request, with
// s_axis_tlast on the final (checksum) byte. Each frame yields exactly one
// result request on m_axis, carrying status, value, split position and
// payload length; a rejected frame gives all zeros. Bytes without tlast
// give no result.
// Throughput: one byte per cycle while m_axis does not stall. The result
// passes through the input register, then the result register.
// cfg_we_i writes expected_version; write only while no frame is in flight.
// Reset clears the frame state and the valid bits of both registers and sets
// the version to 256. When m_axis stalls, the result register holds and the
// input register still takes one more byte if empty before s_axis_tready drops.
`default_nettype none

module command_frame_validator_top #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata    // [2:0] status, [18:3] value,
                                           // [26:19] split_pos, [34:27] payload_len
);

  logic [15:0] version_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  cfv_pkg::result_t out_q;
  cfv_pkg::result_t result;
  logic        advance;
  logic        step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= cfv_pkg::VersionReset;
    end else if (cfg_we_i) begin
      version_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  cfv_frame_check #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .rx_byte_i         (in_byte_q),
    .last_byte_i       (in_last_q),
    .expected_version_i(version_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q};

endmodule

`default_nettype wire

// ===== hw/rtl/cfv_frame_check.sv =====
// Per-byte frame tracking and end-of-frame decode for the command frame validator.
// Depends on cfv_pkg.
`default_nettype none

module cfv_frame_check #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            last_byte_i,
  input  wire logic [15:0]     expected_version_i,
  output cfv_pkg::result_t     result_o
);

  localparam logic [cfv_pkg::IdxW-1:0] IdxLimit = cfv_pkg::IdxW'(MAX_FRAME - 1);

  logic [cfv_pkg::IdxW-1:0] idx_q, idx_d;
  logic        header_q, header_d;
  logic [7:0]  ver_hi_q, ver_hi_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] head_q, head_d;
  logic [7:0]  colon_idx_q, colon_idx_d;
  logic        colon_seen_q, colon_seen_d;

  always_comb begin
    idx_d        = idx_q;
    header_d     = header_q;
    ver_hi_d     = ver_hi_q;
    sum_d        = sum_q;
    cmd_d        = cmd_q;
    len_d        = len_q;
    head_d       = head_q;
    colon_idx_d  = colon_idx_q;
    colon_seen_d = colon_seen_q;
    if (step_i) begin
      if (last_byte_i) begin
        idx_d        = '0;
        header_d     = 1'b0;
        ver_hi_d     = '0;
        sum_d        = '0;
        cmd_d        = '0;
        len_d        = '0;
        head_d       = '0;
        colon_idx_d  = '0;
        colon_seen_d = 1'b0;
      end else begin
        priority if (idx_q == cfv_pkg::IdxW'(0)) begin
          header_d = (rx_byte_i == cfv_pkg::Preamble0);
        end else if (idx_q == cfv_pkg::IdxW'(1)) begin
          header_d = header_q && (rx_byte_i == cfv_pkg::Preamble1);
        end else if (idx_q == cfv_pkg::IdxW'(2)) begin
          ver_hi_d = rx_byte_i;
        end else if (idx_q == cfv_pkg::IdxW'(3)) begin
          header_d = header_q && ({ver_hi_q, rx_byte_i} == expected_version_i);
        end else if (idx_q == cfv_pkg::IdxW'(4)) begin
          cmd_d = rx_byte_i;
        end else if (idx_q == cfv_pkg::IdxW'(5)) begin
          len_d = rx_byte_i;
        end else begin
          if (idx_q == cfv_pkg::IdxW'(6)) begin
            head_d = {rx_byte_i, 8'h00};
          end else if (idx_q == cfv_pkg::IdxW'(7)) begin
            head_d = {head_q[15:8], rx_byte_i};
          end
          if (!colon_seen_q && rx_byte_i == cfv_pkg::ColonChar) begin
            colon_seen_d = 1'b1;
            colon_idx_d  = 8'(idx_q - cfv_pkg::IdxW'(6));
          end
        end
        if (idx_q >= cfv_pkg::IdxW'(2)) begin
          sum_d = sum_q + rx_byte_i;
        end
        if (idx_q != '1) begin
          idx_d = idx_q + cfv_pkg::IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      header_q     <= 1'b0;
      ver_hi_q     <= '0;
      sum_q        <= '0;
      cmd_q        <= '0;
      len_q        <= '0;
      head_q       <= '0;
      colon_idx_q  <= '0;
      colon_seen_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      header_q     <= header_d;
      ver_hi_q     <= ver_hi_d;
      sum_q        <= sum_d;
      cmd_q        <= cmd_d;
      len_q        <= len_d;
      head_q       <= head_d;
      colon_idx_q  <= colon_idx_d;
      colon_seen_q <= colon_seen_d;
    end
  end

  logic frame_ok;
  logic colon_ok;

  // frame length = idx + 1, so L + 7 == length reduces to L + 6 == idx
  assign frame_ok = header_q && (idx_q >= cfv_pkg::IdxW'(6)) && (idx_q <= IdxLimit) &&
                    ({2'b00, len_q} + cfv_pkg::IdxW'(6) == idx_q) && (sum_q == rx_byte_i);
  assign colon_ok = colon_seen_q && ({1'b0, colon_idx_q} + 9'd1 < {1'b0, len_q});

  always_comb begin
    result_o = '0;
    if (frame_ok) begin
      unique case (cmd_q)
        cfv_pkg::CmdQuery: begin
          if (len_q == 8'd1) begin
            if (head_q[15:8] == cfv_pkg::AlarmOn) begin
              result_o.status = cfv_pkg::StQuery;
              result_o.value  = 16'd1;
            end else if (head_q[15:8] == cfv_pkg::AlarmOff) begin
              result_o.status = cfv_pkg::StQuery;
            end
          end
        end
        cfv_pkg::CmdTarget: begin
          if (len_q == 8'd2 && head_q != cfv_pkg::IdNone && head_q != cfv_pkg::IdAll) begin
            result_o.status = cfv_pkg::StTarget;
            result_o.value  = head_q;
          end
        end
        cfv_pkg::CmdWifi, cfv_pkg::CmdHost: begin
          if (len_q > 8'd3 && colon_ok) begin
            result_o.status    = (cmd_q == cfv_pkg::CmdWifi) ? cfv_pkg::StWifi : cfv_pkg::StHost;
            result_o.split_pos = colon_idx_q;
          end
        end
        default: begin
          result_o = '0;
        end
      endcase
      if (result_o.status != cfv_pkg::StReject) begin
        result_o.payload_len = len_q;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfv_checker.sv =====
// Port-level checks for the command frame validator, bound to the top level.
// Depends on command_frame_validator_top.
`default_nettype none

module cfv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result request dropped or changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == cfv_pkg::StReject |-> m_axis_tdata[39:3] == '0)
    else $error("rejected frame with non-zero fields");

  a_query_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == cfv_pkg::StQuery |->
      m_axis_tdata[18:4] == '0 && m_axis_tdata[26:19] == '0 && m_axis_tdata[34:27] == 8'd1)
    else $error("bad query result");

  a_target_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == cfv_pkg::StTarget |->
      m_axis_tdata[18:3] != cfv_pkg::IdNone && m_axis_tdata[18:3] != cfv_pkg::IdAll &&
      m_axis_tdata[34:27] == 8'd2)
    else $error("bad target id result");

endmodule

bind command_frame_validator_top cfv_checker u_cfv_checker (.*);

`default_nettype wire
